FILE: design/mst_pkg.sv
// ----------------------------------------------------------------------------
// mst_pkg
// shared types and constants of the markup segment tokenizer: character
// codes, segment kinds, queue sizes and the words passed between its parts
// ----------------------------------------------------------------------------
`default_nettype none

package mst_pkg;

   // queue sizes
   localparam int FQ_DEPTH = 4;
   localparam int FQ_PTR_W = 2;
   localparam int RQ_DEPTH = 8;
   localparam int RQ_PTR_W = 3;
   localparam int MAX_RES  = 3;

   // characters
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_QMARK = 8'h3F;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;

   // tag prefix handling
   localparam int         PREFIX_LEN    = 10;
   localparam logic [3:0] PREFIX_MAX    = 4'd10;
   localparam logic [3:0] SHORT_TAG_LEN = 4'd6;
   localparam logic [3:0] START_LEN     = 4'd2;
   localparam int         DOCTYPE_LEN   = 9;
   localparam logic [7:0] DOCTYPE_PAT [DOCTYPE_LEN] = '{
      8'h3C, 8'h21, 8'h64, 8'h6F, 8'h63, 8'h74, 8'h79, 8'h70, 8'h65
   };

   // segment kinds
   localparam logic [2:0] KIND_TEXT    = 3'd0;
   localparam logic [2:0] KIND_TAG     = 3'd1;
   localparam logic [2:0] KIND_DECL    = 3'd2;
   localparam logic [2:0] KIND_COMMENT = 3'd3;
   localparam logic [2:0] KIND_NOT_END = 3'd4;

   typedef enum logic [1:0] {
      MODE_TEXT,
      MODE_LT,
      MODE_TAG,
      MODE_COMMENT
   } mode_type;

   // classified input word
   typedef struct packed {
      logic       stream_end;
      logic [7:0] data;
      logic       lt;
      logic       gt;
      logic       blank;
      logic       nl;
   } token_type;

   typedef struct packed {
      logic        event_res;
      logic [7:0]  out_byte;
      logic [2:0]  segment_kind;
      logic [31:0] start_line;
      logic [31:0] start_offset;
      logic        last;
   } result_type;

   // up to three result words written in one cycle
   typedef struct packed {
      logic [1:0]                 count;
      result_type [MAX_RES-1:0]   item;
   } res_write_type;

   function automatic logic [7:0] lower_byte(input logic [7:0] b);
      lower_byte = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      is_blank = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL);
   endfunction

endpackage

`default_nettype wire

FILE: design/mst_front.sv
// ----------------------------------------------------------------------------
// mst_front
// input queue: accepts words, classifies each byte and holds it for the core
// ----------------------------------------------------------------------------
`default_nettype none

module mst_front
   import mst_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_stream_end,
   input  wire logic       push,
   output      logic       full,
   output      token_type  tok,
   output      logic       tok_valid,
   input  wire logic       tok_take
);

   token_type             slot_ff [FQ_DEPTH];
   logic [FQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FQ_PTR_W:0]     count_ff, count_in;
   logic                  accept;
   logic                  take;
   token_type             tok_new;

   assign full      = (count_ff == (FQ_PTR_W+1)'(FQ_DEPTH));
   assign tok_valid = (count_ff != '0);
   assign tok       = slot_ff[rd_ptr_ff];
   assign accept    = push && !full;
   assign take      = tok_take && tok_valid;

   always_comb begin
      tok_new.stream_end = req_stream_end;
      tok_new.data       = req_data_byte;
      tok_new.lt         = (req_data_byte == CH_LT);
      tok_new.gt         = (req_data_byte == CH_GT);
      tok_new.blank      = is_blank(req_data_byte);
      tok_new.nl         = (req_data_byte == CH_NL);
   end

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (FQ_PTR_W+1)'(accept) - (FQ_PTR_W+1)'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= tok_new;
      end
   end

endmodule

`default_nettype wire

FILE: design/mst_core.sv
// ----------------------------------------------------------------------------
// mst_core
// segment state machine: takes one classified word a cycle while the result queue has room
// and writes up to three result words into the result queue
// ----------------------------------------------------------------------------
`default_nettype none

module mst_core
   import mst_pkg::*;
#(
   parameter int COUNT_BITS = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire token_type     tok,
   input  wire logic          tok_valid,
   output      logic          tok_take,
   input  wire logic          room,
   output      res_write_type res_wr
);

   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

   mode_type               mode_ff, mode_in;
   logic [7:0]             prefix_ff [PREFIX_LEN];
   logic [7:0]             tail0_ff, tail0_in;
   logic [7:0]             tail1_ff, tail1_in;
   logic [3:0]             len_ff, len_in;
   logic [COUNT_BITS-1:0]  line_ff, line_in;
   logic [COUNT_BITS-1:0]  byte_ff, byte_in;
   logic [COUNT_BITS-1:0]  sline_ff, sline_in;
   logic [COUNT_BITS-1:0]  soff_ff, soff_in;
   logic                   pend_ff, pend_in;

   logic                   fire;
   logic                   len_open;
   logic [3:0]             len_new;
   logic [7:0]             pn [PREFIX_LEN];
   logic                   cmt_pfx;
   logic                   tail_dd;
   logic                   doc_ok;
   logic [2:0]             cls_kind;
   logic                   tag_done;
   logic [2:0]             tag_kind;
   logic [COUNT_BITS-1:0]  byte_inc;
   logic [COUNT_BITS-1:0]  line_inc;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      sat_inc = (v == CNT_MAX) ? v : v + CNT_ONE;
   endfunction

   function automatic logic [31:0] clip32(input logic [COUNT_BITS-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      clip32 = (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
   endfunction

   function automatic result_type content(input logic [7:0] b);
      result_type r;
      r              = '0;
      r.out_byte     = b;
      content        = r;
   endfunction

   function automatic result_type close_res(input logic [2:0] kind,
                                            input logic [COUNT_BITS-1:0] ln,
                                            input logic [COUNT_BITS-1:0] off);
      result_type r;
      r              = '0;
      r.event_res    = 1'b1;
      r.segment_kind = kind;
      r.start_line   = clip32(ln);
      r.start_offset = clip32(off);
      close_res      = r;
   endfunction

   assign fire     = tok_valid && room;
   assign tok_take = fire;

   // view of the prefix with the current byte already stored
   always_comb begin
      len_open = (len_ff < PREFIX_MAX);
      len_new  = len_open ? len_ff + 4'd1 : len_ff;
      for (int i = 0; i < PREFIX_LEN; i++) begin
         pn[i] = (len_open && len_ff == 4'(i)) ? tok.data : prefix_ff[i];
      end
      cmt_pfx = (pn[0] == CH_LT) && (pn[1] == CH_BANG) &&
                (pn[2] == CH_DASH) && (pn[3] == CH_DASH);
      tail_dd = (tail0_ff == CH_DASH) && (tail1_ff == CH_DASH);
      doc_ok  = is_blank(pn[DOCTYPE_LEN]);
      for (int i = 0; i < DOCTYPE_LEN; i++) begin
         doc_ok = doc_ok && (lower_byte(pn[i]) == DOCTYPE_PAT[i]);
      end
      priority if (len_new < PREFIX_MAX) begin
         cls_kind = KIND_TAG;
      end else if (pn[1] == CH_QMARK || doc_ok) begin
         cls_kind = KIND_DECL;
      end else begin
         cls_kind = KIND_TAG;
      end
      // tag mode, '>' seen: does the segment close and as what
      priority if (len_new < SHORT_TAG_LEN) begin
         tag_done = 1'b1;
         tag_kind = KIND_TAG;
      end else if (!cmt_pfx) begin
         tag_done = 1'b1;
         tag_kind = cls_kind;
      end else if (tail_dd) begin
         tag_done = 1'b1;
         tag_kind = KIND_COMMENT;
      end else begin
         tag_done = 1'b0;
         tag_kind = KIND_COMMENT;
      end
      byte_inc = sat_inc(byte_ff);
      line_inc = tok.nl ? sat_inc(line_ff) : line_ff;
   end

   // next mode
   always_comb begin
      mode_in = mode_ff;
      if (fire) begin
         if (tok.stream_end) begin
            mode_in = MODE_TEXT;
         end else begin
            unique case (mode_ff)
               MODE_TEXT: begin
                  if (tok.lt) mode_in = MODE_LT;
               end
               MODE_LT: begin
                  mode_in = tok.blank ? MODE_TEXT : MODE_TAG;
               end
               MODE_TAG: begin
                  if (tok.gt) mode_in = tag_done ? MODE_TEXT : MODE_COMMENT;
               end
               MODE_COMMENT: begin
                  if (tok.gt && tail_dd) mode_in = MODE_TEXT;
               end
               default: mode_in = MODE_TEXT;
            endcase
         end
      end
   end

   // counters, segment bookkeeping and result words
   always_comb begin
      logic [1:0] n;
      n        = '0;
      res_wr   = '0;
      tail0_in = tail0_ff;
      tail1_in = tail1_ff;
      len_in   = len_ff;
      line_in  = line_ff;
      byte_in  = byte_ff;
      sline_in = sline_ff;
      soff_in  = soff_ff;
      pend_in  = pend_ff;
      if (fire) begin
         if (tok.stream_end) begin
            unique case (mode_ff)
               MODE_TEXT: begin
                  if (pend_ff) begin
                     res_wr.item[n] = close_res(KIND_TEXT, sline_ff, soff_ff);
                     n = n + 2'd1;
                  end
               end
               MODE_LT: begin
                  res_wr.item[n] = content(CH_LT);
                  n = n + 2'd1;
                  res_wr.item[n] = close_res(KIND_TEXT, sline_ff, soff_ff);
                  n = n + 2'd1;
               end
               default: begin
                  res_wr.item[n] = close_res(KIND_NOT_END, sline_ff, soff_ff);
                  n = n + 2'd1;
               end
            endcase
            tail0_in = '0;
            tail1_in = '0;
            len_in   = '0;
            line_in  = CNT_ONE;
            byte_in  = '0;
            sline_in = CNT_ONE;
            soff_in  = '0;
            pend_in  = 1'b0;
         end else begin
            unique case (mode_ff)
               MODE_TEXT: begin
                  if (!tok.lt) begin
                     byte_in = byte_inc;
                     line_in = line_inc;
                     res_wr.item[n] = content(tok.data);
                     n = n + 2'd1;
                     pend_in = 1'b1;
                  end
               end
               MODE_LT: begin
                  // held '<' is counted together with this byte
                  byte_in = (byte_ff >= CNT_MAX - CNT_ONE) ? CNT_MAX
                                                           : byte_ff + COUNT_BITS'(2);
                  line_in = line_inc;
                  if (tok.blank) begin
                     res_wr.item[n] = content(CH_LT);
                     n = n + 2'd1;
                     res_wr.item[n] = content(tok.data);
                     n = n + 2'd1;
                     pend_in = 1'b1;
                  end else begin
                     if (pend_ff) begin
                        res_wr.item[n] = close_res(KIND_TEXT, sline_ff, soff_ff);
                        n = n + 2'd1;
                     end
                     sline_in = line_ff;
                     soff_in  = byte_ff;
                     res_wr.item[n] = content(CH_LT);
                     n = n + 2'd1;
                     res_wr.item[n] = content(tok.data);
                     n = n + 2'd1;
                     len_in   = START_LEN;
                     tail0_in = CH_LT;
                     tail1_in = tok.data;
                     pend_in  = 1'b0;
                  end
               end
               MODE_TAG: begin
                  byte_in = byte_inc;
                  line_in = line_inc;
                  len_in  = len_new;
                  res_wr.item[n] = content(tok.data);
                  n = n + 2'd1;
                  if (tok.gt && tag_done) begin
                     res_wr.item[n] = close_res(tag_kind, sline_ff, soff_ff);
                     n = n + 2'd1;
                     sline_in = line_inc;
                     soff_in  = byte_inc;
                     pend_in  = 1'b0;
                  end else begin
                     tail0_in = tail1_ff;
                     tail1_in = tok.data;
                  end
               end
               MODE_COMMENT: begin
                  byte_in = byte_inc;
                  line_in = line_inc;
                  res_wr.item[n] = content(tok.data);
                  n = n + 2'd1;
                  if (tok.gt && tail_dd) begin
                     res_wr.item[n] = close_res(KIND_COMMENT, sline_ff, soff_ff);
                     n = n + 2'd1;
                     sline_in = line_inc;
                     soff_in  = byte_inc;
                     pend_in  = 1'b0;
                  end else begin
                     tail0_in = tail1_ff;
                     tail1_in = tok.data;
                  end
               end
               default: begin
                  pend_in = 1'b0;
               end
            endcase
         end
         if (n != 2'd0) begin
            res_wr.item[n - 2'd1].last = 1'b1;
         end
      end
      res_wr.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_TEXT;
         tail0_ff <= '0;
         tail1_ff <= '0;
         len_ff   <= '0;
         line_ff  <= CNT_ONE;
         byte_ff  <= '0;
         sline_ff <= CNT_ONE;
         soff_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         tail0_ff <= tail0_in;
         tail1_ff <= tail1_in;
         len_ff   <= len_in;
         line_ff  <= line_in;
         byte_ff  <= byte_in;
         sline_ff <= sline_in;
         soff_ff  <= soff_in;
         pend_ff  <= pend_in;
      end
   end

   // first ten bytes of a tag, read only where already written
   always_ff @(posedge clock) begin
      if (fire && !tok.stream_end) begin
         if (mode_ff == MODE_LT && !tok.blank) begin
            prefix_ff[0] <= CH_LT;
            prefix_ff[1] <= tok.data;
         end else if (mode_ff == MODE_TAG && len_open) begin
            for (int i = 0; i < PREFIX_LEN; i++) begin
               if (len_ff == 4'(i)) prefix_ff[i] <= tok.data;
            end
         end
      end
   end

endmodule

`default_nettype wire

FILE: design/mst_rsp_queue.sv
// ----------------------------------------------------------------------------
// mst_rsp_queue
// result queue: takes up to three result words a cycle, hands out one
// ----------------------------------------------------------------------------
`default_nettype none

module mst_rsp_queue
   import mst_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire res_write_type res_wr,
   output      logic          room,
   output      logic          empty,
   input  wire logic          pop,
   output      result_type    head
);

   result_type            ent_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RQ_PTR_W:0]     count_ff, count_in;
   logic                  take;

   assign empty = (count_ff == '0);
   assign head  = ent_ff[rd_ptr_ff];
   assign take  = pop && !empty;
   // room for the largest burst one word can cause
   assign room  = (count_ff <= (RQ_PTR_W+1)'(RQ_DEPTH - MAX_RES));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RQ_PTR_W'(res_wr.count);
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (RQ_PTR_W+1)'(res_wr.count) - (RQ_PTR_W+1)'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RES; k++) begin
         if (2'(k) < res_wr.count) begin
            ent_ff[wr_ptr_ff + RQ_PTR_W'(k)] <= res_wr.item[k];
         end
      end
   end

endmodule

`default_nettype wire

FILE: design/markup_segment_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// markup_segment_tokenizer_unit
// splits a markup byte stream into text, tag, declaration and comment segments
//
// input side: a queue; a word (byte or end of document) enters at a clock edge
// with push high and full low. result side: a queue; while empty is low the
// oldest result word is on the rsp_ ports and leaves at an edge with pop high.
// each byte is echoed as a content word; a closing segment adds a close word
// with kind, start line and start offset. rsp_last marks the final word that
// one input word caused. a '<' gives no word until the following byte.
// throughput: one input word per cycle while each causes at most one result;
// the result port hands out one word per cycle, so a word causing two or three
// results needs a pop for each. a four-entry input queue and an eight-entry
// result queue take up short stalls; the core waits whenever the result queue
// has fewer than three free entries, and full rises once the input queue is
// full.
// reset empties both queues and returns the line count to one, the byte count
// to zero and the tokenizer to text mode; an end-of-document word does the same
// to the tokenizer after flushing the open segment.
// ----------------------------------------------------------------------------
`default_nettype none

module markup_segment_tokenizer_unit
   import mst_pkg::*;
#(
   parameter int COUNT_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_stream_end,
   input  wire logic        push,
   output      logic        full,
   output      logic        empty,
   input  wire logic        pop,
   output      logic        rsp_event_res,
   output      logic [7:0]  rsp_out_byte,
   output      logic [2:0]  rsp_segment_kind,
   output      logic [31:0] rsp_start_line,
   output      logic [31:0] rsp_start_offset,
   output      logic        rsp_last
);

   token_type     tok;
   logic          tok_valid;
   logic          tok_take;
   logic          room;
   res_write_type res_wr;
   result_type    head;

   mst_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_data_byte  (req_data_byte),
      .req_stream_end (req_stream_end),
      .push           (push),
      .full           (full),
      .tok            (tok),
      .tok_valid      (tok_valid),
      .tok_take       (tok_take)
   );

   mst_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .tok       (tok),
      .tok_valid (tok_valid),
      .tok_take  (tok_take),
      .room      (room),
      .res_wr    (res_wr)
   );

   mst_rsp_queue u_rsp_queue (
      .clock  (clock),
      .reset  (reset),
      .res_wr (res_wr),
      .room   (room),
      .empty  (empty),
      .pop    (pop),
      .head   (head)
   );

   assign rsp_event_res    = head.event_res;
   assign rsp_out_byte     = head.out_byte;
   assign rsp_segment_kind = head.segment_kind;
   assign rsp_start_line   = head.start_line;
   assign rsp_start_offset = head.start_offset;
   assign rsp_last         = head.last;

endmodule

`default_nettype wire

FILE: tb/markup_segment_tokenizer_unit_test.sv
// ----------------------------------------------------------------------------
// markup_segment_tokenizer_unit_test
// drives markup byte streams through the tokenizer and checks every result
// word against a cycle-free model of the segment rules kept in this bench:
// text, held '<', short and long tags, comments, declarations and document
// ends, with random gaps on the input side and random stalls on pop
// ----------------------------------------------------------------------------
module markup_segment_tokenizer_unit_test
   import mst_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 300;
   localparam int DRAIN_CYCLES   = 12;

   logic        clock;
   logic        reset;
   logic [7:0]  req_data_byte;
   logic        req_stream_end;
   logic        push;
   logic        full;
   logic        empty;
   logic        pop;
   logic        rsp_event_res;
   logic [7:0]  rsp_out_byte;
   logic [2:0]  rsp_segment_kind;
   logic [31:0] rsp_start_line;
   logic [31:0] rsp_start_offset;
   logic        rsp_last;

   markup_segment_tokenizer_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_data_byte    (req_data_byte),
      .req_stream_end   (req_stream_end),
      .push             (push),
      .full             (full),
      .empty            (empty),
      .pop              (pop),
      .rsp_event_res    (rsp_event_res),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_segment_kind (rsp_segment_kind),
      .rsp_start_line   (rsp_start_line),
      .rsp_start_offset (rsp_start_offset),
      .rsp_last         (rsp_last)
   );

   // tokenizer model state
   mode_type    tk_mode;
   logic [7:0]  tk_prefix [PREFIX_LEN];
   logic [7:0]  tk_tail [2];
   int          tk_len;
   logic [31:0] tk_lines;
   logic [31:0] tk_bytes;
   logic [31:0] tk_seg_line;
   logic [31:0] tk_seg_off;
   logic        tk_text_open;

   result_type  step_words [MAX_RES];
   int          step_n;
   result_type  expected_words [$];

   int          mismatches;
   int          words_sent;
   int          idle_cycles;
   logic        word_gaps_on;
   logic        pop_stalls_on;

   function automatic logic [31:0] sat_up(input logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction

   function automatic logic is_space_char(input logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB || b == CH_NL;
   endfunction

   function automatic logic [7:0] fold_case(input logic [7:0] b);
      return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
   endfunction

   task automatic clear_state();
      tk_mode = MODE_TEXT;
      foreach (tk_prefix[i]) tk_prefix[i] = '0;
      tk_tail[0] = '0;
      tk_tail[1] = '0;
      tk_len = 0;
      tk_lines = 32'd1;
      tk_bytes = '0;
      tk_seg_line = 32'd1;
      tk_seg_off = '0;
      tk_text_open = 1'b0;
   endtask

   task automatic count_char(input logic [7:0] b);
      tk_bytes = sat_up(tk_bytes);
      if (b == CH_NL) tk_lines = sat_up(tk_lines);
   endtask

   task automatic add_word(input logic ev, input logic [7:0] b, input logic [2:0] kind);
      result_type w;
      w.event_res    = ev;
      w.out_byte     = ev ? 8'd0 : b;
      w.segment_kind = ev ? kind : KIND_TEXT;
      w.start_line   = ev ? tk_seg_line : 32'd0;
      w.start_offset = ev ? tk_seg_off : 32'd0;
      w.last         = 1'b0;
      step_words[step_n] = w;
      step_n++;
   endtask

   task automatic close_segment(input logic [2:0] kind);
      add_word(1'b1, 8'd0, kind);
      tk_seg_line = tk_lines;
      tk_seg_off = tk_bytes;
      tk_mode = MODE_TEXT;
      tk_text_open = 1'b0;
   endtask

   task automatic shift_tail(input logic [7:0] b);
      tk_tail[0] = tk_tail[1];
      tk_tail[1] = b;
   endtask

   function automatic logic [2:0] tag_kind();
      if (tk_len < PREFIX_LEN) return KIND_TAG;
      if (tk_prefix[1] == CH_QMARK) return KIND_DECL;
      for (int i = 0; i < DOCTYPE_LEN; i++)
         if (fold_case(tk_prefix[i]) != DOCTYPE_PAT[i]) return KIND_TAG;
      return is_space_char(tk_prefix[9]) ? KIND_DECL : KIND_TAG;
   endfunction

   // works out the result words of one accepted input word
   task automatic tokenize_word(input logic [7:0] b, input logic se);
      logic dash_pair;
      step_n = 0;
      if (se) begin
         case (tk_mode)
            MODE_TEXT: begin
               if (tk_text_open) close_segment(KIND_TEXT);
            end
            MODE_LT: begin
               count_char(CH_LT);
               add_word(1'b0, CH_LT, KIND_TEXT);
               close_segment(KIND_TEXT);
            end
            default: begin
               close_segment(KIND_NOT_END);
            end
         endcase
         clear_state();
      end else begin
         case (tk_mode)
            MODE_TEXT: begin
               if (b == CH_LT) begin
                  tk_mode = MODE_LT;
               end else begin
                  count_char(b);
                  add_word(1'b0, b, KIND_TEXT);
                  tk_text_open = 1'b1;
               end
            end
            MODE_LT: begin
               if (is_space_char(b)) begin
                  count_char(CH_LT);
                  count_char(b);
                  add_word(1'b0, CH_LT, KIND_TEXT);
                  add_word(1'b0, b, KIND_TEXT);
                  tk_text_open = 1'b1;
                  tk_mode = MODE_TEXT;
               end else begin
                  if (tk_text_open) close_segment(KIND_TEXT);
                  tk_seg_line = tk_lines;
                  tk_seg_off = tk_bytes;
                  count_char(CH_LT);
                  count_char(b);
                  add_word(1'b0, CH_LT, KIND_TEXT);
                  add_word(1'b0, b, KIND_TEXT);
                  tk_prefix[0] = CH_LT;
                  tk_prefix[1] = b;
                  tk_len = int'(START_LEN);
                  tk_tail[0] = CH_LT;
                  tk_tail[1] = b;
                  tk_text_open = 1'b0;
                  tk_mode = MODE_TAG;
               end
            end
            MODE_TAG: begin
               count_char(b);
               add_word(1'b0, b, KIND_TEXT);
               if (tk_len < PREFIX_LEN) begin
                  tk_prefix[tk_len] = b;
                  tk_len++;
               end
               if (b == CH_GT) begin
                  dash_pair = tk_tail[0] == CH_DASH && tk_tail[1] == CH_DASH;
                  if (tk_len < SHORT_TAG_LEN) begin
                     close_segment(KIND_TAG);
                  end else if (!(tk_prefix[0] == CH_LT && tk_prefix[1] == CH_BANG &&
                                 tk_prefix[2] == CH_DASH && tk_prefix[3] == CH_DASH)) begin
                     close_segment(tag_kind());
                  end else if (dash_pair) begin
                     close_segment(KIND_COMMENT);
                  end else begin
                     // comment opener without a closing dash pair runs on
                     shift_tail(b);
                     tk_mode = MODE_COMMENT;
                  end
               end else begin
                  shift_tail(b);
               end
            end
            default: begin
               count_char(b);
               add_word(1'b0, b, KIND_TEXT);
               if (b == CH_GT && tk_tail[0] == CH_DASH && tk_tail[1] == CH_DASH)
                  close_segment(KIND_COMMENT);
               else
                  shift_tail(b);
            end
         endcase
      end
      if (step_n > 0) step_words[step_n - 1].last = 1'b1;
      for (int i = 0; i < step_n; i++) expected_words = {expected_words, step_words[i]};
   endtask

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   // entered and left at a falling edge; push stays high for the next word
   task automatic send_word(input logic [7:0] b, input logic se);
      if (word_gaps_on && $urandom_range(0, 4) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_data_byte <= b;
      req_stream_end <= se;
      push <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      tokenize_word(b, se);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_chars(input string s);
      for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
   endtask

   task automatic send_end();
      send_word(8'($urandom_range(0, 255)), 1'b1);
   endtask

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 2))
         0: return CH_SPACE;
         1: return CH_TAB;
         default: return CH_NL;
      endcase
   endfunction

   function automatic logic [7:0] byte_except(input logic [7:0] avoid);
      logic [7:0] v;
      do v = 8'($urandom_range(0, 255)); while (v == avoid);
      return v;
   endfunction

   function automatic logic [7:0] tame_byte();
      case ($urandom_range(0, 5))
         0: return CH_DASH;
         1: return CH_NL;
         2: return CH_GT;
         default: return 8'($urandom_range(8'h61, 8'h7A));
      endcase
   endfunction

   // one well-formed or deliberately broken piece of a document
   task automatic send_segment(input int pick);
      string name;
      logic [7:0] c;
      case (pick)
         0, 1: begin
            repeat ($urandom_range(1, 6))
               send_word(($urandom_range(0, 3) == 0) ? CH_NL : byte_except(CH_LT), 1'b0);
         end
         2: begin
            send_word(CH_LT, 1'b0);
            send_word(pick_blank(), 1'b0);
         end
         3: begin
            send_word(CH_LT, 1'b0);
            repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
            send_word(CH_GT, 1'b0);
         end
         4: begin
            send_word(CH_LT, 1'b0);
            repeat ($urandom_range(4, 12)) send_word(byte_except(CH_GT), 1'b0);
            send_word(CH_GT, 1'b0);
         end
         5: begin
            send_chars("<!--");
            repeat ($urandom_range(0, 4)) send_word(tame_byte(), 1'b0);
            send_chars("-->");
         end
         6: begin
            // stray '>' inside the comment keeps it open unless the byte before it is a dash
            send_chars("<!--");
            send_word(byte_except(CH_GT), 1'b0);
            send_word(CH_GT, 1'b0);
            repeat ($urandom_range(0, 2)) send_word(tame_byte(), 1'b0);
            send_chars("-->");
         end
         7: begin
            send_word(CH_LT, 1'b0);
            send_word(CH_QMARK, 1'b0);
            repeat ($urandom_range(5, 10)) send_word(byte_except(CH_GT), 1'b0);
            send_word(CH_GT, 1'b0);
         end
         8: begin
            name = "doctype";
            send_word(CH_LT, 1'b0);
            send_word(CH_BANG, 1'b0);
            for (int i = 0; i < name.len(); i++) begin
               c = name[i];
               if ($urandom_range(0, 1) == 1) c = c - 8'd32;
               send_word(c, 1'b0);
            end
            send_word(($urandom_range(0, 3) == 0) ? 8'h78 : pick_blank(), 1'b0);
            send_chars("html>");
         end
         9: begin
            send_end();
         end
         10: begin
            repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(0, 255)), 1'b0);
         end
         default: begin
            // document ends with something still open
            case ($urandom_range(0, 2))
               0: send_word(CH_LT, 1'b0);
               1: send_chars("<ab");
               default: send_chars("<!--x>");
            endcase
            send_end();
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   task automatic test_text_and_held_lt();
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(CH_NL, 1'b0);
      send_chars("<\ta< <\n");
      send_end();
   endtask

   task automatic test_short_tag_and_lt_at_end();
      send_chars("<b>z<");
      send_end();
   endtask

   task automatic test_comment_and_open_tag();
      send_chars("<!---->");
      send_chars("<?");
      send_end();
   endtask

   task automatic test_random_documents(input int count);
      int stop_at;
      stop_at = words_sent + count;
      for (int k = 0; k <= 11; k++) send_segment(k);
      while (words_sent < stop_at) send_segment($urandom_range(0, 11));
   endtask

   task automatic test_back_to_back(input int count);
      int stop_at;
      stop_at = words_sent + count;
      word_gaps_on = 1'b0;
      pop_stalls_on = 1'b0;
      while (words_sent < stop_at) send_segment($urandom_range(0, 11));
      send_end();
   endtask

   // ------------------------------------------------------------------------
   // clock, result port, watchdog
   // ------------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      int stall_left;
      stall_left = 0;
      pop = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
         end else if (pop_stalls_on && $urandom_range(0, 4) == 0) begin
            pop <= 1'b0;
            stall_left = $urandom_range(0, 2);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && pop && !empty) begin
         if (expected_words.size() == 0) begin
            $error("result word with nothing expected");
            mismatches++;
         end else begin
            want = expected_words.pop_front();
            check_field("event_res", want.event_res, rsp_event_res);
            check_field("out_byte", want.out_byte, rsp_out_byte);
            check_field("segment_kind", want.segment_kind, rsp_segment_kind);
            check_field("start_line", want.start_line, rsp_start_line);
            check_field("start_offset", want.start_offset, rsp_start_offset);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      push = 1'b0;
      req_data_byte = '0;
      req_stream_end = 1'b0;
      mismatches = 0;
      words_sent = 0;
      idle_cycles = 0;
      word_gaps_on = 1'b1;
      pop_stalls_on = 1'b1;
      clear_state();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_text_and_held_lt();
      test_short_tag_and_lt_at_end();
      test_comment_and_open_tag();
      test_random_documents(60);
      test_back_to_back(12);

      push <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

FILE: filelist.f
design/mst_pkg.sv
design/mst_front.sv
design/mst_core.sv
design/mst_rsp_queue.sv
design/markup_segment_tokenizer_unit.sv
tb/markup_segment_tokenizer_unit_test.sv
